// File: rtl/reversible_deque_macros.svh
// Assertion macros used by the reversible deque controller.
`ifndef REVERSIBLE_DEQUE_MACROS_SVH
`define REVERSIBLE_DEQUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("reversible_deque assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("reversible_deque assertion failed");

`endif

// File: rtl/rd_pkg.sv
// Shared types, codes and defaults of the reversible deque.
package rd_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int POS_W          = 10;
	localparam int COUNT_W        = 11;

	typedef enum logic [1:0] {
		CMD_REVERSE   = 2'd0,
		CMD_ADD_FRONT = 2'd1,
		CMD_ADD_BACK  = 2'd2,
		CMD_READ      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_RSVD  = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_READ = 3'b100
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic latch;      // capture the accepted item
		logic exec;       // update pointers and store, load non-read results
		logic load_read;  // load the registered store word into the output
	} ctrl_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic is_read;
	} dp_stat_t;

endpackage

// File: rtl/rd_ctrl.sv
// Controller state machine of the reversible deque.
module rd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  rd_pkg::dp_stat_t stat,
	output rd_pkg::ctrl_cmd_t cmd_o
);
	import rd_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd_o.latch     = 1'b0;
		cmd_o.exec      = 1'b0;
		cmd_o.load_read = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_o.latch = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd_o.exec = 1'b1;
					state_d    = stat.is_read ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				cmd_o.load_read = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((cmd_o.exec && !stat.is_read) || cmd_o.load_read) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`include "reversible_deque_macros.svh"

	`RD_ASSERT_NXT(a_accept_to_exec, clk, arst_n, accept, state_q == ST_EXEC)
	`RD_ASSERT_NXT(a_read_loads_out, clk, arst_n, state_q == ST_READ,
		out_valid_q && state_q == ST_IDLE)
	`RD_ASSERT_NXT(a_exec_loads_out, clk, arst_n, cmd_o.exec && !stat.is_read,
		out_valid_q && state_q == ST_IDLE)
	`RD_ASSERT_IMP(a_exec_out_free, clk, arst_n, cmd_o.exec, out_free)

endmodule

// File: rtl/rd_dpath.sv
// Datapath of the reversible deque: pointers, count, flag, element store, output register.
module rd_dpath #(
	parameter int DEPTH      = rd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rd_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rd_pkg::ctrl_cmd_t            cmd_i,
	output rd_pkg::dp_stat_t             stat,
	input  logic [1:0]                   cmd,
	input  logic signed [rd_pkg::VALUE_W-1:0] value,
	input  logic [rd_pkg::POS_W-1:0]     position,
	output logic signed [rd_pkg::VALUE_W-1:0] data,
	output logic [rd_pkg::COUNT_W-1:0]   count,
	output logic [1:0]                   status
);
	import rd_pkg::*;

	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMPW  = (CW > POS_W) ? CW : POS_W;
	localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [PW-1:0]          head_q;
	logic [CW-1:0]          count_q;
	logic                   rev_q;

	cmd_t                   cmd_q;
	logic [VALUE_W-1:0]     value_q;
	logic [POS_W-1:0]       pos_q;

	logic [DATA_WIDTH-1:0]  rd_q;
	logic                   rd_ok_q;

	logic signed [VALUE_W-1:0] data_q;
	logic [COUNT_W-1:0]     count_out_q;
	stat_t                  status_q;

	logic                   is_read, is_push, full, push_ok, to_front, rd_ok;
	logic [CW-1:0]          phys, offset, count_next;
	logic [PW:0]            sum, slot_w;
	logic [PW-1:0]          slot, front_slot, wr_slot;
	logic [DATA_WIDTH-1:0]  word;
	logic signed [EXT_W-1:0] rd_ext;

	assign is_read = (cmd_q == CMD_READ);
	assign is_push = (cmd_q == CMD_ADD_FRONT) || (cmd_q == CMD_ADD_BACK);
	assign full    = (count_q == CW'(DEPTH));
	assign push_ok = is_push && !full;
	assign to_front = (cmd_q == CMD_ADD_FRONT) != rev_q;
	assign rd_ok   = is_read && (CMPW'(pos_q) < CMPW'(count_q));

	// Logical index to physical offset from the head; valid only in range.
	assign phys   = rev_q ? (count_q - CW'(1) - CW'(pos_q)) : CW'(pos_q);
	assign offset = is_read ? phys : count_q;
	assign sum    = (PW+1)'(head_q) + (PW+1)'(offset);
	assign slot_w = (sum >= (PW+1)'(DEPTH)) ? (sum - (PW+1)'(DEPTH)) : sum;
	assign slot   = slot_w[PW-1:0];

	assign front_slot = (head_q == '0) ? PW'(DEPTH - 1) : (head_q - PW'(1));
	assign wr_slot    = to_front ? front_slot : slot;
	assign count_next = push_ok ? (count_q + CW'(1)) : count_q;

	assign word   = DATA_WIDTH'(EXT_W'(value_q));
	assign rd_ext = EXT_W'($signed(rd_q));

	assign stat.is_read = is_read;

	// Hold the accepted item.
	always_ff @(posedge clk) begin
		if (cmd_i.latch) begin
			cmd_q   <= cmd_t'(cmd);
			value_q <= value;
			pos_q   <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd_i.exec) begin
			if (cmd_q == CMD_REVERSE) begin
				rev_q <= !rev_q;
			end
			if (push_ok && to_front) begin
				head_q <= front_slot;
			end
			count_q <= count_next;
		end
	end

	// Element store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd_i.exec && push_ok) begin
			mem[wr_slot] <= word;
		end
		if (cmd_i.exec && rd_ok) begin
			rd_q <= mem[slot];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd_i.exec) begin
			rd_ok_q     <= rd_ok;
			data_q      <= '0;
			count_out_q <= COUNT_W'(count_next);
			if (is_push && full) begin
				status_q <= STAT_FULL;
			end else begin
				status_q <= STAT_OK;
			end
		end else if (cmd_i.load_read) begin
			data_q   <= rd_ok_q ? rd_ext[VALUE_W-1:0] : '0;
			status_q <= rd_ok_q ? STAT_OK : STAT_RANGE;
		end
	end

	assign data   = data_q;
	assign count  = count_out_q;
	assign status = status_q;

endmodule

// File: rtl/reversible_deque.sv
// Top level of the reversible deque: controller and datapath.
//
// A double-ended queue of up to DEPTH signed elements held in a circular
// store, with a reversal flag so that reversing the whole queue is a single
// command. Each accepted item (a reverse, a push at the logical front or
// back, or a read by logical index) yields exactly one result item carrying
// the data read (zero otherwise), the element count after the command and a
// status: ok, push dropped because full, or read index out of range. One item
// is worked on at a time. After acceptance the update state changes the pointers,
// count, flag and store once the output is free; a reverse or push has its
// result loaded into the output register by that update, a read by the
// read state that follows it, since the store has a single registered read
// port and its word comes back through a register. The input stalls until
// the controller is idle again, so a new item is taken only once the last is through.
// A result waiting on a stalled output holds back the next item's update
// cycle for as long as the stall lasts. No clearing pass follows reset; the
// store contents are undefined until written, and only written slots are
// ever read.
module reversible_deque #(
	parameter int DEPTH      = rd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rd_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        cmd,
	input  logic signed [rd_pkg::VALUE_W-1:0] value,
	input  logic [rd_pkg::POS_W-1:0]          position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rd_pkg::VALUE_W-1:0] data,
	output logic [rd_pkg::COUNT_W-1:0]        count,
	output logic [1:0]                        status
);
	import rd_pkg::*;

	// Command and status between the two halves.
	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	// Sequence accept, update and result load.
	rd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd_o     (ctrl_cmd)
	);

	// Hold the pointers, count, flag, store and output register.
	rd_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_i    (ctrl_cmd),
		.stat     (dp_stat),
		.cmd      (cmd),
		.value    (value),
		.position (position),
		.data     (data),
		.count    (count),
		.status   (status)
	);

endmodule
